/* design/rer_pkg.sv */
// Shared types, constants and decode helpers for the rotary encoder register slave.
// Used by rer_ram, rer_ctrl and i2c_rotary_encoder_register_slave_unit.
// No dependencies.
package rer_pkg;

    // Register map.
    localparam logic [7:0] SOFT_RESET_ADDR = 8'h00;
    localparam logic [7:0] CONFIG_ADDR     = 8'h01;
    localparam logic [7:0] COUNT_HI_ADDR   = 8'h03;
    localparam logic [7:0] COUNT_LO_ADDR   = 8'h04;
    localparam logic [7:0] PUSH_COUNT_ADDR = 8'h05;
    localparam logic [7:0] PUSH_STATE_ADDR = 8'h06;
    localparam logic [7:0] ANIM_ADDR       = 8'h0E;
    localparam logic [7:0] ANIM_SET_ADDR   = 8'h0F;
    localparam logic [7:0] LED_BASE_ADDR   = 8'h10;
    localparam int         LED_COUNT       = 12;
    localparam logic [8:0] LED_END_ADDR    = 9'(16 + LED_COUNT);
    localparam logic [7:0] GP_BASE_ADDR    = 8'd32;

    // Encoder direction options fixed at build time.
    localparam logic TRIGGER_TOGGLE = 1'b0;
    localparam logic DIRECTION_FLIP = 1'b0;

    // Config byte bits.
    localparam int CFG_DIR_FLIP   = 0;
    localparam int CFG_ROT_CLEAR  = 1;
    localparam int CFG_PUSH_CLEAR = 2;
    localparam int CFG_PUSH_DEC   = 3;
    localparam int CFG_PUSH_FLIP  = 4;
    localparam logic [7:0] CFG_WRITE_MASK = 8'h3F;

    // Reset values of the guard registers.
    localparam logic [7:0] BUTTON_GUARD_RESET  = 8'd50;
    localparam logic [7:0] ENCODER_GUARD_RESET = 8'd1;

    // Configuration port register indexes.
    localparam logic REG_BUTTON_GUARD  = 1'b0;
    localparam logic REG_ENCODER_GUARD = 1'b1;

    // Event codes.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_MATCH  = 3'd1;
    localparam logic [2:0] OP_RX     = 3'd2;
    localparam logic [2:0] OP_TX     = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_BUTTON = 3'd5;
    localparam logic [2:0] OP_ENC    = 3'd6;

    // Bus phases.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ADDR   = 2'd1;
    localparam logic [1:0] PH_PTR    = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    localparam int MEM_DEPTH = 256;
    localparam int ADDR_W    = 8;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       soft_reset;
        logic       mark_dirty;
        logic       anim_select_write;
        logic       anim_settings_write;
        logic [7:0] written_byte;
    } res_t;

    function automatic logic is_led(input logic [7:0] r);
        return (r >= LED_BASE_ADDR) && ({1'b0, r} < LED_END_ADDR);
    endfunction

    function automatic logic is_writable(input logic [7:0] r);
        return (r == CONFIG_ADDR)
            || ((r >= COUNT_HI_ADDR) && (r <= PUSH_COUNT_ADDR))
            || (r == ANIM_ADDR) || (r == ANIM_SET_ADDR)
            || is_led(r)
            || (r >= GP_BASE_ADDR);
    endfunction

    // Registers kept in flops rather than in the byte memory.
    function automatic logic is_flop_reg(input logic [7:0] r);
        return (r == CONFIG_ADDR) || (r == COUNT_HI_ADDR) || (r == COUNT_LO_ADDR)
            || (r == PUSH_COUNT_ADDR) || (r == PUSH_STATE_ADDR);
    endfunction

endpackage

/* design/rer_ram.sv */
// Register byte memory: 256 x 8, one write and one registered read per cycle.
// Per-entry valid bits make every entry read as zero until first written.
// Depends on rer_pkg.
module rer_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  rer_pkg::mem_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0]                  mem_reg [rer_pkg::MEM_DEPTH];
    logic [rer_pkg::MEM_DEPTH-1:0] valid_reg;
    logic [7:0]                  rdata_reg;
    logic                        rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem_reg[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rvalid_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'h00;

endmodule

/* design/rer_ctrl.sv */
// Event sequencer: decodes one item, updates pointer, phase, timers and the
// counter registers, and drives the byte memory. Depends on rer_pkg.
module rer_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        in_opcode,
    input  logic              in_master_reads,
    input  logic [7:0]        in_rx_byte,
    input  logic              in_button_pin_high,
    input  logic              in_enc_a_level,
    input  logic              in_enc_b_level,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata,
    output rer_pkg::mem_req_t mem_req,
    input  logic [7:0]        mem_rdata,
    output logic              res_valid,
    output rer_pkg::res_t     res,
    input  logic              res_take
);

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RDWAIT, ST_HOLD} state_t;

    state_t        state_reg, state_next;
    logic [2:0]    op_reg;
    logic          reads_reg, pin_reg, a_reg, b_reg;
    logic [7:0]    rx_reg;
    logic [7:0]    ptr_reg, ptr_next;
    logic [1:0]    phase_reg, phase_next;
    logic [31:0]   time_reg, time_next;
    logic [31:0]   last_btn_reg, last_btn_next;
    logic [31:0]   last_enc_reg, last_enc_next;
    logic [7:0]    btn_guard_reg, enc_guard_reg;
    logic [7:0]    cfg_reg, cfg_next;
    logic [7:0]    hi_reg, hi_next;
    logic [7:0]    lo_reg, lo_next;
    logic [7:0]    push_reg, push_next;
    logic          pstate_reg, pstate_next;
    rer_pkg::res_t res_reg, res_next;

    logic          in_fire;
    logic          pstate_new;
    logic [7:0]    flop_val;
    logic [31:0]   btn_elapsed, enc_elapsed;
    logic          enc_up;
    logic [15:0]   count_new;
    logic [7:0]    wr_data;

    assign in_fire     = in_valid && in_ready;
    assign in_ready    = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_HOLD);
    assign res         = res_reg;
    assign pstate_new  = (!pin_reg) ^ cfg_reg[rer_pkg::CFG_PUSH_FLIP];
    assign btn_elapsed = time_reg - last_btn_reg;
    assign enc_elapsed = time_reg - last_enc_reg;
    assign enc_up      = (rer_pkg::TRIGGER_TOGGLE ? (a_reg ^ b_reg) : b_reg)
                         ^ rer_pkg::DIRECTION_FLIP ^ cfg_reg[rer_pkg::CFG_DIR_FLIP];
    assign count_new   = enc_up ? ({hi_reg, lo_reg} + 16'd1) : ({hi_reg, lo_reg} - 16'd1);
    assign wr_data     = (ptr_reg == rer_pkg::CONFIG_ADDR)
                         ? (rx_reg & rer_pkg::CFG_WRITE_MASK) : rx_reg;

    // Value of a flop-held register as seen by a read of the current pointer.
    always_comb
    begin
        flop_val = 8'h00;
        if (ptr_reg == rer_pkg::CONFIG_ADDR)
        begin
            flop_val = cfg_reg;
        end
        else if (ptr_reg == rer_pkg::COUNT_HI_ADDR)
        begin
            flop_val = hi_reg;
        end
        else if (ptr_reg == rer_pkg::COUNT_LO_ADDR)
        begin
            flop_val = lo_reg;
        end
        else if (ptr_reg == rer_pkg::PUSH_COUNT_ADDR)
        begin
            flop_val = push_reg;
        end
        else if (ptr_reg == rer_pkg::PUSH_STATE_ADDR)
        begin
            flop_val = {7'd0, pstate_new};
        end
    end

    always_comb
    begin
        logic do_send;
        logic do_write;
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        phase_next    = phase_reg;
        time_next     = time_reg;
        last_btn_next = last_btn_reg;
        last_enc_next = last_enc_reg;
        cfg_next      = cfg_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        push_next     = push_reg;
        pstate_next   = pstate_reg;
        res_next      = res_reg;
        mem_req       = '0;
        do_send       = 1'b0;
        do_write      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next   = '0;
                state_next = ST_HOLD;
                case (op_reg)
                    rer_pkg::OP_TICK:
                    begin
                        time_next = time_reg + 32'd1;
                    end
                    rer_pkg::OP_MATCH:
                    begin
                        if (!reads_reg)
                        begin
                            phase_next = rer_pkg::PH_ADDR;
                        end
                        else
                        begin
                            phase_next = rer_pkg::PH_PTR;
                            do_send    = 1'b1;
                        end
                    end
                    rer_pkg::OP_RX:
                    begin
                        if (phase_reg == rer_pkg::PH_ADDR)
                        begin
                            ptr_next   = rx_reg;
                            phase_next = rer_pkg::PH_PTR;
                        end
                        else if (phase_reg == rer_pkg::PH_PTR)
                        begin
                            do_write = 1'b1;
                        end
                    end
                    rer_pkg::OP_TX:
                    begin
                        do_send = (phase_reg == rer_pkg::PH_PTR);
                    end
                    rer_pkg::OP_STOP:
                    begin
                        phase_next = rer_pkg::PH_IDLE;
                    end
                    rer_pkg::OP_BUTTON:
                    begin
                        if (!pin_reg && (btn_elapsed >= {24'd0, btn_guard_reg}))
                        begin
                            last_btn_next = time_reg;
                            if (cfg_reg[rer_pkg::CFG_PUSH_DEC])
                            begin
                                if (push_reg != 8'h00)
                                begin
                                    push_next = push_reg - 8'd1;
                                end
                            end
                            else
                            begin
                                push_next = push_reg + 8'd1;
                            end
                        end
                    end
                    rer_pkg::OP_ENC:
                    begin
                        if (enc_elapsed >= {24'd0, enc_guard_reg})
                        begin
                            last_enc_next = time_reg;
                            hi_next       = count_new[15:8];
                            lo_next       = count_new[7:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (do_send)
                begin
                    res_next.tx_valid = 1'b1;
                    if (rer_pkg::is_flop_reg(ptr_reg))
                    begin
                        res_next.tx_byte = flop_val;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = ptr_reg;
                        state_next    = ST_RDWAIT;
                    end
                    if (ptr_reg == rer_pkg::PUSH_STATE_ADDR)
                    begin
                        pstate_next = pstate_new;
                    end
                    // Clear-on-read takes effect after the byte has been sampled.
                    if ((ptr_reg == rer_pkg::COUNT_LO_ADDR) && cfg_reg[rer_pkg::CFG_ROT_CLEAR])
                    begin
                        hi_next = 8'h00;
                        lo_next = 8'h00;
                    end
                    if ((ptr_reg == rer_pkg::PUSH_COUNT_ADDR)
                        && cfg_reg[rer_pkg::CFG_PUSH_CLEAR])
                    begin
                        push_next = 8'h00;
                    end
                    ptr_next = ptr_reg + 8'd1;
                end

                if (do_write)
                begin
                    if (ptr_reg == rer_pkg::SOFT_RESET_ADDR)
                    begin
                        res_next.soft_reset = (rx_reg != 8'h00);
                    end
                    else if (rer_pkg::is_writable(ptr_reg))
                    begin
                        res_next.written_byte        = wr_data;
                        res_next.mark_dirty          = (ptr_reg == rer_pkg::CONFIG_ADDR)
                                                       || rer_pkg::is_led(ptr_reg);
                        res_next.anim_select_write   = (ptr_reg == rer_pkg::ANIM_ADDR);
                        res_next.anim_settings_write = (ptr_reg == rer_pkg::ANIM_SET_ADDR);
                        if (ptr_reg == rer_pkg::CONFIG_ADDR)
                        begin
                            cfg_next = wr_data;
                        end
                        else if (ptr_reg == rer_pkg::COUNT_HI_ADDR)
                        begin
                            hi_next = wr_data;
                        end
                        else if (ptr_reg == rer_pkg::COUNT_LO_ADDR)
                        begin
                            lo_next = wr_data;
                        end
                        else if (ptr_reg == rer_pkg::PUSH_COUNT_ADDR)
                        begin
                            push_next = wr_data;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = ptr_reg;
                            mem_req.wdata = wr_data;
                        end
                    end
                    ptr_next = ptr_reg + 8'd1;
                end
            end
            ST_RDWAIT:
            begin
                res_next.tx_byte = mem_rdata;
                state_next       = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= rer_pkg::OP_TICK;
            reads_reg     <= 1'b0;
            rx_reg        <= 8'h00;
            pin_reg       <= 1'b1;
            a_reg         <= 1'b0;
            b_reg         <= 1'b0;
            ptr_reg       <= 8'h00;
            phase_reg     <= rer_pkg::PH_IDLE;
            time_reg      <= '0;
            last_btn_reg  <= '0;
            last_enc_reg  <= '0;
            btn_guard_reg <= rer_pkg::BUTTON_GUARD_RESET;
            enc_guard_reg <= rer_pkg::ENCODER_GUARD_RESET;
            cfg_reg       <= 8'h00;
            hi_reg        <= 8'h00;
            lo_reg        <= 8'h00;
            push_reg      <= 8'h00;
            pstate_reg    <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            phase_reg    <= phase_next;
            time_reg     <= time_next;
            last_btn_reg <= last_btn_next;
            last_enc_reg <= last_enc_next;
            cfg_reg      <= cfg_next;
            hi_reg       <= hi_next;
            lo_reg       <= lo_next;
            push_reg     <= push_next;
            pstate_reg   <= pstate_next;
            res_reg      <= res_next;
            if (in_fire)
            begin
                op_reg    <= in_opcode;
                reads_reg <= in_master_reads;
                rx_reg    <= in_rx_byte;
                pin_reg   <= in_button_pin_high;
                a_reg     <= in_enc_a_level;
                b_reg     <= in_enc_b_level;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    rer_pkg::REG_BUTTON_GUARD:  btn_guard_reg <= cfg_wdata;
                    rer_pkg::REG_ENCODER_GUARD: enc_guard_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // An accepted item is always decoded in the very next cycle.
    a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted item not decoded next cycle");

    // The memory is never read and written in the same cycle.
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write collide");

    // The bus phase never reaches its unused code.
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != rer_pkg::PH_UNUSED)
        else $error("bus phase reached unused code");

    // The two top config bits are always masked off.
    a_cfg_mask: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_reg[7:6] == 2'b00)
        else $error("config byte holds masked bits");

    // A result without a transmitted byte carries a zero byte.
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.tx_valid || (res.tx_byte == 8'h00)))
        else $error("tx byte nonzero without tx valid");

endmodule

/* design/i2c_rotary_encoder_register_slave_unit.sv */
// Top level of the rotary encoder register slave: stream ports, output register,
// sequencer and register memory. Depends on rer_pkg, rer_ram and rer_ctrl.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   event item (tuser kind, tdata fields)
//  m_axis    out        m_axis_tvalid / m_axis_tready   one result item per event
//  cfg       in         cfg_we (no wait)                guard register writes
//
// An item's result is formed in the decode state and held in the sequencer until it is taken
// into the output register; a read of a byte held in the memory first passes a wait state.
// One item is in work at a time; the next is accepted the cycle after its result is
// handed on to the output register.
// A result waiting in the output register does not block acceptance of the next item.
// Reset is asynchronous, active low; memory entries read as zero until written.
// Output stalls hold the result in the sequencer until the output register frees up.
module i2c_rotary_encoder_register_slave_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] master_reads, [8:1] rx_byte, [9] button_pin_high, [10] enc_a_level,
    // [11] enc_b_level, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] soft_reset, [10] mark_dirty,
    // [11] anim_select_write, [12] anim_settings_write, [20:13] written_byte, [23:21] zero
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    rer_pkg::mem_req_t mem_req;
    logic [7:0]        mem_rdata;
    logic              res_valid;
    logic              res_take;
    rer_pkg::res_t     res;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    rer_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    rer_ctrl u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .in_opcode          (s_axis_tuser),
        .in_master_reads    (s_axis_tdata[0]),
        .in_rx_byte         (s_axis_tdata[8:1]),
        .in_button_pin_high (s_axis_tdata[9]),
        .in_enc_a_level     (s_axis_tdata[10]),
        .in_enc_b_level     (s_axis_tdata[11]),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .mem_req            (mem_req),
        .mem_rdata          (mem_rdata),
        .res_valid          (res_valid),
        .res                (res),
        .res_take           (res_take)
    );

    assign res_take = res_valid && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            if (res_take)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {3'b000, res.written_byte, res.anim_settings_write,
                                res.anim_select_write, res.mark_dirty, res.soft_reset,
                                res.tx_byte, res.tx_valid};
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
